FILE: hw/rtl/ccr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ccr_pkg
// Shared types and constants for the 8-connected region counter.
// ============================================================================
package ccr_pkg;

    localparam int unsigned DimWidth   = 7;
    localparam int unsigned CountWidth = 11;
    localparam logic [CountWidth-1:0] CountLimit = 11'd2047;

    // Register indexes on the configuration port.
    localparam int unsigned RegRows    = 0;
    localparam int unsigned RegColumns = 1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_write;    // store the incoming pixel
        logic clear_step;    // clear one visited entry at the scan index
        logic scan_reset;    // restart the scan index at zero
        logic scan_read;     // read image and visited at the scan index
        logic scan_next;     // advance the scan index
        logic seed;          // start a region at the scan index
        logic pop;           // advance the queue head
        logic pop_take;      // latch the popped cell
        logic nb_read;       // read image and visited of the current neighbor
        logic nb_take;       // enqueue the neighbor if it is set and unvisited
        logic nb_next;       // advance to the next neighbor
        logic count_clear;   // clear the region total
    } ccr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;     // scan index is the last cell
        logic scan_hit;      // scanned cell is set and unvisited
        logic queue_empty;   // queue head has reached tail
        logic nb_last;       // current neighbor is the eighth
        logic nb_inside;     // current neighbor lies in the image
    } ccr_stat_t;

    // Neighbor offsets, row then column.
    function automatic logic signed [1:0] row_step(input logic [2:0] k);
        unique case (k)
            3'd0, 3'd1, 3'd7: row_step = 2'sd1;
            3'd2, 3'd6:       row_step = 2'sd0;
            default:          row_step = -2'sd1;
        endcase
    endfunction

    function automatic logic signed [1:0] col_step(input logic [2:0] k);
        unique case (k)
            3'd0, 3'd4: col_step = 2'sd0;
            3'd1, 3'd2, 3'd3: col_step = -2'sd1;
            default:    col_step = 2'sd1;
        endcase
    endfunction

endpackage

FILE: hw/rtl/ccr_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// ccr_ram
// Generic single-port RAM with registered read data.
// ============================================================================
module ccr_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: hw/rtl/ccr_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// ccr_datapath
// Image, visited and queue memories with the address and count registers.
// ============================================================================
module ccr_datapath
    import ccr_pkg::*;
#(
    parameter int unsigned MAX_ROWS    = 64,
    parameter int unsigned MAX_COLUMNS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ccr_cmd_t              cmd,
    output ccr_stat_t             stat,
    input  logic                  pixel,
    input  logic                  load_reset,
    output logic                  load_last,
    input  logic [DimWidth-1:0]   row_count,
    input  logic [DimWidth-1:0]   column_count,
    output logic [CountWidth-1:0] region_total
);

    localparam int unsigned Cells = MAX_ROWS * MAX_COLUMNS;
    localparam int unsigned AW    = $clog2(Cells);
    localparam int unsigned RW    = $clog2(MAX_ROWS + 1);
    localparam int unsigned CW    = $clog2(MAX_COLUMNS + 1);
    localparam int unsigned QW    = $clog2(Cells + 1);
    localparam int unsigned PW    = RW + CW;

    // Dimensions in use, clamped.
    logic [RW-1:0] rows;
    logic [CW-1:0] cols;
    logic [AW:0]   size;

    always_comb
    begin
        if (row_count == '0)
            rows = RW'(1);
        else if (32'(row_count) > MAX_ROWS)
            rows = RW'(MAX_ROWS);
        else
            rows = RW'(row_count);
        if (column_count == '0)
            cols = CW'(1);
        else if (32'(column_count) > MAX_COLUMNS)
            cols = CW'(MAX_COLUMNS);
        else
            cols = CW'(column_count);
    end

    assign size = (AW+1)'(rows) * (AW+1)'(cols);

    // Load position. A position past the frame end restarts at zero.
    logic [AW:0] load_pos_reg;
    logic [AW:0] load_pos;
    assign load_pos  = (load_pos_reg >= size) ? '0 : load_pos_reg;
    assign load_last = (load_pos + 1'b1 >= size);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            load_pos_reg <= '0;
        else if (load_reset)
            load_pos_reg <= '0;
        else if (cmd.load_write)
            load_pos_reg <= load_last ? '0 : load_pos + 1'b1;
    end

    // Scan index kept as a row and column pair as well as a flat address.
    logic [AW-1:0] scan_reg;
    logic [RW-1:0] srow_reg;
    logic [CW-1:0] scol_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.scan_reset)
        begin
            scan_reg <= '0;
            srow_reg <= '0;
            scol_reg <= '0;
        end
        else if (cmd.scan_next)
        begin
            scan_reg <= scan_reg + 1'b1;
            if (scol_reg == cols - 1'b1)
            begin
                scol_reg <= '0;
                srow_reg <= srow_reg + 1'b1;
            end
            else
            begin
                scol_reg <= scol_reg + 1'b1;
            end
        end
    end
    assign stat.scan_last = ({1'b0, scan_reg} + 1'b1 == size);

    // Current cell being expanded and neighbor counter.
    logic [RW-1:0] crow_reg;
    logic [CW-1:0] ccol_reg;
    logic [2:0]    k_reg;
    logic [QW-1:0] head_reg;
    logic [QW-1:0] tail_reg;
    logic [PW-1:0] q_rdata;

    // Neighbor coordinates.
    logic signed [RW+1:0] nr;
    logic signed [CW+1:0] nc;
    logic [RW-1:0]        nr_u;
    logic [CW-1:0]        nc_u;
    logic [AW-1:0]        n_addr;

    always_comb
    begin
        nr = $signed({2'b00, crow_reg}) + (RW+2)'(row_step(k_reg));
        nc = $signed({2'b00, ccol_reg}) + (CW+2)'(col_step(k_reg));
        nr_u = nr[RW-1:0];
        nc_u = nc[CW-1:0];
        n_addr = AW'(PW'(nr_u) * PW'(cols) + PW'(nc_u));
    end
    assign stat.nb_inside = (nr >= 0) && (nr < $signed({2'b00, rows}))
                         && (nc >= 0) && (nc < $signed({2'b00, cols}));
    assign stat.nb_last   = (k_reg == 3'd7);
    assign stat.queue_empty = (head_reg == tail_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.pop_take)
        begin
            // Queue entries carry the row and column of a cell.
            crow_reg <= q_rdata[PW-1:CW];
            ccol_reg <= q_rdata[CW-1:0];
            k_reg    <= '0;
        end
        else if (cmd.nb_next)
        begin
            k_reg <= k_reg + 1'b1;
        end
    end

    // Memory ports.
    logic          img_we, img_wd, img_rd;
    logic [AW-1:0] img_addr;
    logic          vis_we, vis_wd, vis_rd;
    logic [AW-1:0] vis_addr;
    logic          q_we;
    logic [AW-1:0] q_addr;
    logic [PW-1:0] q_wdata;

    always_comb
    begin
        img_we   = cmd.load_write;
        img_wd   = pixel;
        img_addr = cmd.load_write ? AW'(load_pos) :
                   (cmd.nb_read ? n_addr : scan_reg);
        vis_we   = cmd.clear_step || cmd.seed || (cmd.nb_take && stat.nb_inside
                   && img_rd && !vis_rd);
        vis_wd   = !cmd.clear_step;
        vis_addr = (cmd.nb_read || cmd.nb_take) ? n_addr : scan_reg;
        q_we     = cmd.seed || (cmd.nb_take && stat.nb_inside && img_rd && !vis_rd);
        q_wdata  = cmd.seed ? {srow_reg, scol_reg} : {nr_u, nc_u};
        // A new region starts its queue at the bottom.
        q_addr   = cmd.seed ? '0 : (q_we ? AW'(tail_reg) : AW'(head_reg));
    end

    assign stat.scan_hit = img_rd && !vis_rd;

    ccr_ram #(.WIDTH(1), .DEPTH(Cells)) u_image (
        .clk(clk), .we(img_we), .addr(img_addr), .wdata(img_wd), .rdata(img_rd)
    );
    ccr_ram #(.WIDTH(1), .DEPTH(Cells)) u_visited (
        .clk(clk), .we(vis_we), .addr(vis_addr), .wdata(vis_wd), .rdata(vis_rd)
    );
    ccr_ram #(.WIDTH(PW), .DEPTH(Cells)) u_queue (
        .clk(clk), .we(q_we), .addr(q_addr), .wdata(q_wdata), .rdata(q_rdata)
    );

    // Queue pointers and region total.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            region_total <= '0;
        end
        else
        begin
            if (cmd.count_clear)
                region_total <= '0;
            if (cmd.seed)
            begin
                head_reg <= '0;
                tail_reg <= QW'(1);
                if (region_total != CountLimit)
                    region_total <= region_total + 1'b1;
            end
            else
            begin
                if (q_we)
                    tail_reg <= tail_reg + 1'b1;
                if (cmd.pop)
                    head_reg <= head_reg + 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/ccr_control.sv
`timescale 1ns / 1ps
// ============================================================================
// ccr_control
// Sequencer for loading, clearing, scanning and the flood fill.
// ============================================================================
module ccr_control
    import ccr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  logic      load_last,
    output logic      out_valid,
    input  logic      out_stall,
    output ccr_cmd_t  cmd,
    input  ccr_stat_t stat
);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_SREAD = 4'd2;
    localparam logic [3:0] S_SWAIT = 4'd3;
    localparam logic [3:0] S_SCHK  = 4'd4;
    localparam logic [3:0] S_POP   = 4'd5;
    localparam logic [3:0] S_PWAIT = 4'd6;
    localparam logic [3:0] S_PTAKE = 4'd7;
    localparam logic [3:0] S_NREAD = 4'd8;
    localparam logic [3:0] S_NWAIT = 4'd9;
    localparam logic [3:0] S_NTAKE = 4'd10;
    localparam logic [3:0] S_SNEXT = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign out_valid = out_valid_reg;
    assign in_stall  = (state_reg != S_LOAD);
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    cmd.load_write = 1'b1;
                    if (load_last)
                    begin
                        cmd.scan_reset  = 1'b1;
                        cmd.count_clear = 1'b1;
                        state_next      = S_CLEAR;
                    end
                end
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.scan_last)
                begin
                    cmd.scan_reset = 1'b1;
                    state_next     = S_SREAD;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_SREAD: state_next = S_SWAIT;
            S_SWAIT: state_next = S_SCHK;
            S_SCHK:
            begin
                if (stat.scan_hit)
                begin
                    cmd.seed   = 1'b1;
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_SNEXT;
                end
            end
            S_POP:
            begin
                if (stat.queue_empty)
                begin
                    state_next = S_SNEXT;
                end
                else
                begin
                    state_next = S_PWAIT;
                end
            end
            S_PWAIT: state_next = S_PTAKE;
            S_PTAKE:
            begin
                // The head moves in the same cycle that its entry is latched.
                cmd.pop      = 1'b1;
                cmd.pop_take = 1'b1;
                state_next   = S_NREAD;
            end
            S_NREAD:
            begin
                cmd.nb_read = 1'b1;
                state_next  = S_NWAIT;
            end
            S_NWAIT:
            begin
                cmd.nb_read = 1'b1;
                state_next  = S_NTAKE;
            end
            S_NTAKE:
            begin
                cmd.nb_take = 1'b1;
                if (stat.nb_last)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    cmd.nb_next = 1'b1;
                    state_next  = S_NREAD;
                end
            end
            S_SNEXT:
            begin
                if (stat.scan_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SREAD;
                end
            end
            S_DONE:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hw/rtl/count_8_connected_regions_top.sv
`timescale 1ns / 1ps
// ============================================================================
// count_8_connected_regions_top
// Counts 8-connected regions of set pixels in a binary image.
// ============================================================================
// Channel  Direction  Handshake                Payload
// input    in         in_valid / in_stall      pixel
// output   out        out_valid / out_stall    region_count
// config   in         APB write                row_count, column_count
//
// Loading takes one pixel per cycle while in_stall is low. Then the visited
// map is cleared cell by cell and the scan reads, waits for and checks each
// cell; a set, unvisited cell seeds a flood fill that pops each queued cell
// and reads, waits for and takes its eight neighbors until the queue is empty.
// Reset sets both dimensions to 64 and starts an empty frame.
// The count waits in an output register, so a stalled count does not hold up
// loading; the next count waits until the previous one is taken.
// ============================================================================
module count_8_connected_regions_top
    import ccr_pkg::*;
#(
    parameter int unsigned MAX_ROWS    = 64,
    parameter int unsigned MAX_COLUMNS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  pixel,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CountWidth-1:0] region_count,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [DimWidth-1:0]   row_count_reg, column_count_reg;
    logic [CountWidth-1:0] total;
    logic [CountWidth-1:0] result_reg;
    logic                  cfg_write, load_last, out_valid_i;
    ccr_cmd_t              cmd;
    ccr_stat_t             stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= DimWidth'(64);
            column_count_reg <= DimWidth'(64);
        end
        else if (cfg_write)
        begin
            if (paddr[2] == RegRows[0])
                row_count_reg <= pwdata[DimWidth-1:0];
            else
                column_count_reg <= pwdata[DimWidth-1:0];
        end
    end

    assign prdata = (paddr[2] == RegColumns[0]) ? 32'(column_count_reg)
                                                  : 32'(row_count_reg);

    always_ff @(posedge clk)
    begin
        if (!out_valid_i || !out_stall)
            result_reg <= total;
    end
    assign region_count = result_reg;
    assign out_valid    = out_valid_i;

    ccr_control u_control (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .load_last(load_last), .out_valid(out_valid_i), .out_stall(out_stall),
        .cmd(cmd), .stat(stat)
    );

    ccr_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS)) u_datapath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .pixel(pixel),
        .load_reset(cfg_write), .load_last(load_last),
        .row_count(row_count_reg), .column_count(column_count_reg),
        .region_total(total)
    );

endmodule

FILE: hw/rtl/ccr_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// ccr_checker
// Port-level checks for the region counter.
// ============================================================================
module ccr_checker
    import ccr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [CountWidth-1:0] region_count,
    input logic                  pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(region_count))
        else $error("result changed while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(region_count))
        else $error("unknown result while valid");

    a_ctrl_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_stall, out_valid}))
        else $error("unknown handshake signal");

endmodule

bind count_8_connected_regions_top ccr_checker u_ccr_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .region_count(region_count), .pready(pready)
);
